/* rtl/brl_pkg.sv */
// Shared types and constants for the line rasterizer.
package brl_pkg;

  localparam int unsigned CoordW      = 6;
  localparam int unsigned RegW        = 7;
  localparam int unsigned ErrW        = 9;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned TileSizeDef = 64;
  localparam int unsigned InDataW     = 24;
  localparam int unsigned OutDataW    = 24;

  localparam logic [CfgIdxW-1:0] CfgWidthIdx  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHeightIdx = 8'd1;

  localparam logic [RegW-1:0] WidthRst  = 7'd64;
  localparam logic [RegW-1:0] HeightRst = 7'd64;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StRun
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last_pix;
    logic out_free;
  } status_t;

endpackage

/* rtl/brl_ctrl.sv */
// Sequencer for segment load, setup and pixel stepping.
module brl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  brl_pkg::status_t status_i,
  output brl_pkg::cmd_t    cmd_o
);
  import brl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StSetup;
      end
      StSetup: begin
        state_d = StRun;
      end
      StRun: begin
        if (status_i.out_free && status_i.last_pix) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
      end
      StRun: begin
        cmd_o.step = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/brl_datapath.sv */
// Coordinate, error and output registers of the line rasterizer.
module brl_datapath #(
  parameter int unsigned TILE_SIZE = brl_pkg::TileSizeDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  brl_pkg::cmd_t                    cmd_i,
  output brl_pkg::status_t                 status_o,
  input  logic [brl_pkg::InDataW-1:0]      in_data_i,
  input  logic                             width_we_i,
  input  logic                             height_we_i,
  input  logic [brl_pkg::RegW-1:0]         cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [brl_pkg::OutDataW-1:0]     out_data_o,
  output logic                             out_inside_o,
  output logic                             out_last_o
);
  import brl_pkg::*;

  localparam logic [CoordW-1:0] MaxCoord = CoordW'(TILE_SIZE - 1);

  function automatic logic [CoordW-1:0] clamp(input logic [CoordW-1:0] v);
    clamp = (v > MaxCoord) ? MaxCoord : v;
  endfunction

  function automatic logic [CoordW-1:0] absdiff(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  logic [RegW-1:0]   width_q, height_q;
  logic [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [CoordW-1:0] x_q, y_q, xend_q, dx_q, dy_q, idx_q;
  logic              steep_q, yneg_q;
  logic signed [ErrW-1:0] err_q;

  logic              out_valid_q;
  logic [CoordW-1:0] opx_q, opy_q, oidx_q, ocnt_q;
  logic              oinside_q, olast_q;

  // setup terms
  logic              steep;
  logic [CoordW-1:0] a0, a1, b0, b1, sx, sy, ex, ey;
  logic              swap;

  // step terms
  logic signed [ErrW-1:0] err_sum, err_adj;
  logic              err_over;
  logic [CoordW-1:0] px, py;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else begin
      if (width_we_i)  width_q  <= cfg_data_i;
      if (height_we_i) height_q <= cfg_data_i;
    end
  end

  always_comb begin
    steep = absdiff(by_q, ay_q) > absdiff(bx_q, ax_q);
    a0    = steep ? ay_q : ax_q;
    a1    = steep ? ax_q : ay_q;
    b0    = steep ? by_q : bx_q;
    b1    = steep ? bx_q : by_q;
    swap  = a0 > b0;
    sx    = swap ? b0 : a0;
    sy    = swap ? b1 : a1;
    ex    = swap ? a0 : b0;
    ey    = swap ? a1 : b1;
  end

  always_comb begin
    err_sum  = err_q + $signed({2'b00, dy_q, 1'b0});
    err_over = err_sum > $signed({3'b000, dx_q});
    err_adj  = err_sum - $signed({2'b00, dx_q, 1'b0});
    px       = steep_q ? y_q : x_q;
    py       = steep_q ? x_q : y_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= clamp(in_data_i[CoordW-1:0]);
      ay_q <= clamp(in_data_i[2*CoordW-1:CoordW]);
      bx_q <= clamp(in_data_i[3*CoordW-1:2*CoordW]);
      by_q <= clamp(in_data_i[4*CoordW-1:3*CoordW]);
    end
    if (cmd_i.setup) begin
      steep_q <= steep;
      x_q     <= sx;
      y_q     <= sy;
      xend_q  <= ex;
      dx_q    <= ex - sx;
      dy_q    <= absdiff(ey, sy);
      yneg_q  <= !(ey > sy);
      err_q   <= '0;
      idx_q   <= '0;
    end else if (cmd_i.step) begin
      x_q   <= x_q + 1'b1;
      idx_q <= idx_q + 1'b1;
      if (err_over) begin
        y_q   <= yneg_q ? (y_q - 1'b1) : (y_q + 1'b1);
        err_q <= err_adj;
      end else begin
        err_q <= err_sum;
      end
    end
    if (cmd_i.step) begin
      opx_q     <= px;
      opy_q     <= py;
      oinside_q <= ({1'b0, px} < width_q) && ({1'b0, py} < height_q);
      oidx_q    <= idx_q;
      ocnt_q    <= dx_q;
      olast_q   <= (x_q == xend_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last_pix = (x_q == xend_q);

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = {ocnt_q, oidx_q, opy_q, opx_q};
  assign out_inside_o = oinside_q;
  assign out_last_o   = olast_q;

endmodule

/* rtl/bresenham_line_rasterizer_core.sv */
// Top level of the Bresenham line rasterizer.
// Usage:
//   s_axis carries one segment per transaction; tdata holds start_x,
//   start_y, end_x, end_y (6 bits each, lowest first). Coordinates above
//   TILE_SIZE-1 saturate to TILE_SIZE-1.
//   m_axis carries one pixel per transaction in major-axis order; tlast
//   marks the segment's final pixel, tuser says the pixel lies inside
//   the visible width and height.
//   cfg writes width_in_use (index 0) and height_in_use (index 1); other
//   indexes are ignored. Write only while no segment is in flight.
// Flow:
//   A taken segment passes the endpoint, stepping and output registers
//   before its first pixel shows on m_axis; then one pixel per cycle while
//   m_axis_tready holds, step_count+1 pixels in all, from the single
//   stepping unit that walks the major axis.
//   s_axis_tready is high only between segments; the next segment is
//   taken while the final pixel still waits in the output register.
// Reset: both registers return to 64, no pixel is pending.
// Stall: a low m_axis_tready while a pixel waits freezes the stepping unit; no pixel is lost.
module bresenham_line_rasterizer_core #(
  parameter int unsigned TILE_SIZE = brl_pkg::TileSizeDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [brl_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y, step_index, step_count
  output logic [brl_pkg::OutDataW-1:0]   m_axis_tdata,
  // inside_res
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [brl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [brl_pkg::RegW-1:0]       cfg_data_i
);
  import brl_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    width_we, height_we;

  assign cfg_ready_o = 1'b1;
  assign width_we    = cfg_valid_i && (cfg_index_i == CfgWidthIdx);
  assign height_we   = cfg_valid_i && (cfg_index_i == CfgHeightIdx);

  brl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  brl_datapath #(
    .TILE_SIZE (TILE_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (s_axis_tdata),
    .width_we_i   (width_we),
    .height_we_i  (height_we),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_inside_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

/* rtl/brl_checker.sv */
// Port-level checks for the line rasterizer, bound to the top level.
module brl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [brl_pkg::InDataW-1:0]    s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [brl_pkg::OutDataW-1:0]   m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [brl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input logic [brl_pkg::RegW-1:0]       cfg_data_i
);
  import brl_pkg::*;

  logic [CoordW-1:0] idx, cnt;
  assign idx = m_axis_tdata[3*CoordW-1:2*CoordW];
  assign cnt = m_axis_tdata[4*CoordW-1:3*CoordW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("pixel changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("segment taken while previous one in setup");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> idx <= cnt)
    else $error("step index beyond step count");

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (idx == cnt)))
    else $error("last flag disagrees with step index");

endmodule

bind bresenham_line_rasterizer_core brl_checker u_brl_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the Bresenham line rasterizer core.
`timescale 1ns / 1ps

module testbench;
  import brl_pkg::*;

  localparam int TileMax = TileSizeDef - 1;

  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgTopIdx    = 8'hFF;

  typedef struct {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              in_view;
    logic [CoordW-1:0] index;
    logic [CoordW-1:0] count;
    logic              last;
  } pixel_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [RegW-1:0]     cfg_data_i    = '0;

  logic [InDataW-1:0] segment_q[$];
  pixel_t             pixel_q[$];
  logic [RegW-1:0]    visible_w = WidthRst;
  logic [RegW-1:0]    visible_h = HeightRst;
  int unsigned        sender_idle_pct = 0;
  int unsigned        ready_stall_pct = 0;
  int unsigned        fail_count      = 0;
  int unsigned        segments_done   = 0;
  int unsigned        pixels_seen     = 0;
  int unsigned        reg_writes      = 0;

  always #4ns clk_i = ~clk_i;

  bresenham_line_rasterizer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [InDataW-1:0] seg(int sx, int sy, int ex, int ey);
    return {ey[CoordW-1:0], ex[CoordW-1:0], sy[CoordW-1:0], sx[CoordW-1:0]};
  endfunction

  // Expected pixels of one segment, appended to pixel_q.
  function automatic void rasterize_segment(logic [InDataW-1:0] segment);
    int     c[4];
    int     ax, ay, bx, by, t, dx, dy, ystep, err, y;
    bit     steep;
    pixel_t p;
    for (int i = 0; i < 4; i++) begin
      c[i] = segment[i*CoordW +: CoordW];
      if (c[i] > TileMax) c[i] = TileMax;
    end
    ax = c[0];
    ay = c[1];
    bx = c[2];
    by = c[3];
    steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx    = bx - ax;
    dy    = (by > ay) ? by - ay : ay - by;
    ystep = (by > ay) ? 1 : -1;
    err   = 0;
    y     = ay;
    for (int x = ax; x <= bx; x++) begin
      p.x       = steep ? y[CoordW-1:0] : x[CoordW-1:0];
      p.y       = steep ? x[CoordW-1:0] : y[CoordW-1:0];
      p.in_view = (p.x < visible_w) && (p.y < visible_h);
      p.index   = CoordW'(x - ax);
      p.count   = CoordW'(dx);
      p.last    = (x == bx);
      pixel_q.push_back(p);
      err += 2 * dy;
      if (err > dx) begin
        y   += ystep;
        err -= 2 * dx;
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fail_count++;
    end
  endfunction

  function automatic logic [InDataW-1:0] random_segment();
    int sx, sy, ex, ey;
    sx = $urandom_range(0, TileMax);
    sy = $urandom_range(0, TileMax);
    ex = $urandom_range(0, TileMax);
    ey = $urandom_range(0, TileMax);
    // short segments keep back-to-back transactions frequent
    if ($urandom_range(0, 3) == 0) begin
      ex = sx + $urandom_range(0, 6) - 3;
      ey = sy + $urandom_range(0, 6) - 3;
      ex = (ex < 0) ? 0 : (ex > TileMax) ? TileMax : ex;
      ey = (ey < 0) ? 0 : (ey > TileMax) ? TileMax : ey;
    end
    return seg(sx, sy, ex, ey);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgWidthIdx) visible_w = value;
    else if (idx == CfgHeightIdx) visible_h = value;
    reg_writes++;
  endtask

  task automatic wait_idle();
    while (segment_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // segment driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        rasterize_segment(s_axis_tdata);
        segments_done++;
      end
      if (segment_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= segment_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // pixel monitor
  always @(posedge clk_i) begin : pixel_monitor
    pixel_t exp_pix;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel transaction: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_pix = pixel_q.pop_front();
          check_field("pixel_x", exp_pix.x, m_axis_tdata[0 +: CoordW]);
          check_field("pixel_y", exp_pix.y, m_axis_tdata[CoordW +: CoordW]);
          check_field("inside_res", exp_pix.in_view, m_axis_tuser);
          check_field("step_index", exp_pix.index, m_axis_tdata[2*CoordW +: CoordW]);
          check_field("step_count", exp_pix.count, m_axis_tdata[3*CoordW +: CoordW]);
          check_field("last", exp_pix.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned        phase_w[5]    = '{1, 0, 127, 65, 0};
    int unsigned        phase_h[5]    = '{1, 64, 17, 0, 0};
    int unsigned        phase_send[5] = '{75, 0, 12, 0, 75};
    int unsigned        phase_stal[5] = '{0, 75, 12, 0, 0};
    logic [InDataW-1:0] directed[$];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{seg(0, 0, 0, 0), seg(63, 63, 63, 63), seg(0, 0, 63, 0),
                 seg(63, 63, 0, 63), seg(0, 0, 0, 63), seg(63, 63, 63, 0),
                 seg(0, 0, 63, 63), seg(63, 0, 0, 63), seg(0, 63, 63, 0),
                 seg(5, 10, 40, 20), seg(40, 20, 5, 10), seg(10, 5, 20, 40),
                 seg(20, 40, 10, 5), seg(10, 40, 20, 5), seg(7, 7, 8, 8),
                 seg(30, 30, 31, 30), seg(30, 30, 30, 31), seg(0, 63, 1, 0),
                 seg(63, 0, 62, 63), seg(12, 3, 50, 4)};
    foreach (directed[i]) segment_q.push_back(directed[i]);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 3) begin
        // out-of-range indexes must leave both registers alone
        write_reg(CfgUnusedIdx, 7'd5);
        write_reg(CfgTopIdx, 7'd1);
      end
      if (ph == 4) begin
        phase_w[4] = $urandom_range(1, 64);
        phase_h[4] = $urandom_range(1, 64);
      end
      write_reg(CfgWidthIdx, RegW'(phase_w[ph]));
      write_reg(CfgHeightIdx, RegW'(phase_h[ph]));
      sender_idle_pct = phase_send[ph];
      ready_stall_pct = phase_stal[ph];
      repeat (38) segment_q.push_back(random_segment());
      wait_idle();
    end
    write_reg(CfgWidthIdx, WidthRst);
    write_reg(CfgHeightIdx, HeightRst);

    $display("Covered %0d segments and %0d pixels over %0d register writes,",
             segments_done, pixels_seen, reg_writes);
    $display("with idle-free, sender-idle, receiver-stall and mixed traffic.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/brl_pkg.sv
rtl/brl_ctrl.sv
rtl/brl_datapath.sv
rtl/bresenham_line_rasterizer_core.sv
rtl/brl_checker.sv
dv/testbench.sv
